// ===== hdl/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants of the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int MAX_LEN = 256;
  localparam int BUF_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CNT_W   = $clog2(MAX_LEN + 1) + 1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5
  } action_t;

  // one result on its way to the output register
  typedef struct packed {
    action_t    action;
    logic [7:0] bus_byte;
    logic       use_ram;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       done_res;
    logic       error;
    logic       busy_res;
  } stage_t;

  // transmit buffer port requests
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hdl/i2cmts_ram.sv =====
// ----------------------------------------------------------------------------
// i2cmts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module i2cmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/i2cmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cmts_ctrl
// Message state, event counter and per-transaction decision stage.
// ----------------------------------------------------------------------------
module i2cmts_ctrl
  import i2cmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       advance,
  input  logic [1:0] command,
  input  logic [7:0] index,
  input  logic [7:0] data,
  input  logic       direction,
  input  logic [6:0] address,
  input  logic [8:0] length,
  input  logic       ack_missing,
  input  logic [7:0] rx_byte,
  output logic       stage_valid,
  output stage_t     stage,
  output ram_req_t   ram_req
);

  logic             active, active_next;
  logic             read_mode, read_mode_next;
  logic [LEN_W-1:0] message_length, message_length_next;
  logic [CNT_W-1:0] event_count, event_count_next;
  logic             stage_valid_next;
  stage_t           stage_next;
  logic [CNT_W-1:0] cnt_n;
  logic [CNT_W-1:0] len_ext;
  logic [LEN_W-1:0] len_clamped;
  action_t          resume;

  always_comb begin
    cnt_n   = event_count + CNT_W'(1);
    len_ext = CNT_W'(message_length);
    resume  = (cnt_n == len_ext - CNT_W'(1)) ? ACT_NACK : ACT_ACK;
    if (length == 9'd0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(length) > MAX_LEN) begin
      len_clamped = LEN_W'(MAX_LEN);
    end else begin
      len_clamped = LEN_W'(length);
    end
  end

  always_comb begin
    active_next         = active;
    read_mode_next      = read_mode;
    message_length_next = message_length;
    event_count_next    = event_count;
    stage_next          = '0;
    stage_next.action   = ACT_NONE;
    ram_req             = '0;
    ram_req.waddr       = BUF_AW'(index);
    ram_req.wdata       = data;
    ram_req.raddr       = BUF_AW'(cnt_n);

    if (accept) begin
      case (cmd_t'(command))
        CMD_LOAD: begin
          ram_req.we = (32'(index) < MAX_LEN);
        end
        CMD_START: begin
          if (!active) begin
            active_next         = 1'b1;
            read_mode_next      = direction;
            message_length_next = len_clamped;
            event_count_next    = '1;
            stage_next.action   = ACT_START;
            stage_next.bus_byte = {address, direction};
          end
        end
        CMD_EVENT: begin
          if (active) begin
            event_count_next = cnt_n;
            if (cnt_n == '0 && ack_missing) begin
              // address not acknowledged
              active_next         = 1'b0;
              stage_next.action   = ACT_STOP;
              stage_next.done_res = 1'b1;
              stage_next.error    = 1'b1;
            end else if (!read_mode) begin
              if (cnt_n < len_ext) begin
                stage_next.action  = ACT_SEND;
                stage_next.use_ram = (32'(cnt_n) < MAX_LEN);
                ram_req.re         = 1'b1;
              end else begin
                active_next         = 1'b0;
                stage_next.action   = ACT_STOP;
                stage_next.done_res = 1'b1;
              end
            end else begin
              stage_next.rx_index = 8'(cnt_n - CNT_W'(1));
              stage_next.rx_data  = rx_byte;
              if (cnt_n == '0) begin
                stage_next.action   = resume;
                stage_next.rx_index = '0;
                stage_next.rx_data  = '0;
              end else if (cnt_n < len_ext) begin
                stage_next.action   = resume;
                stage_next.rx_valid = 1'b1;
              end else begin
                // final byte goes out with the stop
                active_next         = 1'b0;
                stage_next.action   = ACT_STOP;
                stage_next.rx_valid = 1'b1;
                stage_next.done_res = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    stage_next.busy_res = active_next;
  end

  always_comb begin
    if (accept) begin
      stage_valid_next = 1'b1;
    end else if (advance) begin
      stage_valid_next = 1'b0;
    end else begin
      stage_valid_next = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      read_mode      <= 1'b0;
      message_length <= '0;
      event_count    <= '1;
      stage_valid    <= 1'b0;
    end else begin
      active         <= active_next;
      read_mode      <= read_mode_next;
      message_length <= message_length_next;
      event_count    <= event_count_next;
      stage_valid    <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_START && !active |=> event_count == '1 && active)
    else $error("start did not arm the event counter");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    active && event_count != '1 |-> event_count < len_ext)
    else $error("event counter ran past the message length");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    accept && stage_next.done_res |=> !active)
    else $error("message still active after stop");
`endif

endmodule

// ===== hdl/i2c_master_transfer_sequencer.sv =====
// A transaction is registered in the decision stage, then in the output register.
// Throughput: one transaction per cycle unless the output stalls; the decision
// stage refills while a result waits under stall, so input stalls only when both
// stages are full. The transmit byte comes from a registered-read buffer read
// in the decision cycle. Reset clears the message state, sets the event counter
// to all ones and empties both stages; the transmit buffer is not cleared.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences one i2c master message, one bus byte-complete event at a time.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [7:0] index,
  input  logic [7:0] data,
  input  logic       direction,
  input  logic [6:0] address,
  input  logic [8:0] length,
  input  logic       ack_missing,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] action,
  output logic [7:0] bus_byte,
  output logic       rx_valid,
  output logic [7:0] rx_index,
  output logic [7:0] rx_data,
  output logic       done_res,
  output logic       error,
  output logic       busy_res
);

  logic       accept;
  logic       advance;
  logic       stage_valid;
  stage_t     stage;
  ram_req_t   ram_req;
  logic [7:0] ram_q;

  assign advance   = stage_valid && (!res_valid || !res_stall);
  assign cmd_stall = stage_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  i2cmts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .advance     (advance),
    .command     (command),
    .index       (index),
    .data        (data),
    .direction   (direction),
    .address     (address),
    .length      (length),
    .ack_missing (ack_missing),
    .rx_byte     (rx_byte),
    .stage_valid (stage_valid),
    .stage       (stage),
    .ram_req     (ram_req)
  );

  i2cmts_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action   <= stage.action;
      bus_byte <= stage.use_ram ? ram_q : stage.bus_byte;
      rx_valid <= stage.rx_valid;
      rx_index <= stage.rx_index;
      rx_data  <= stage.rx_data;
      done_res <= stage.done_res;
      error    <= stage.error;
      busy_res <= stage.busy_res;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !stage_valid)
    else $error("stages not empty after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && res_valid && res_stall |=> stage_valid && $stable(stage))
    else $error("decision stage lost a pending result");

  a_error_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid && error |-> done_res && action == ACT_STOP && !busy_res)
    else $error("error without a stop");

  a_rx_action: assert property (@(posedge clk) disable iff (rst)
    res_valid && rx_valid |->
      action == ACT_ACK || action == ACT_NACK || action == ACT_STOP)
    else $error("received byte on a wrong action");
`endif

endmodule
